/* rtl/core/nfsc_pkg.sv */
// Shared types, constants and helpers for the navmesh face segment collider.
`default_nettype none
package nfsc_pkg;

	localparam int NFSC_MAX_VERTICES = 16;
	localparam int CW  = 32;      // coordinate width, Q16.16
	localparam int DW  = 50;      // distance accumulator width
	localparam int NW  = 51;      // divider operand magnitude width
	localparam int DVW = NW + 16; // divider dividend width (fraction appended)
	localparam int XW  = 52;      // wide signed working width
	localparam int EW  = CW * 3 + CW * 3 + 1; // vertex entry width

	localparam logic [15:0] TOL_RESET = 16'd7;
	localparam logic [16:0] F_ONE     = 17'h10000;

	typedef enum logic [1:0] {
		K_FACE  = 2'd0,
		K_VERT  = 2'd1,
		K_QUERY = 2'd2,
		K_NONE  = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		OC_NONE   = 2'd0,
		OC_SURF   = 2'd1,
		OC_WALL   = 2'd2,
		OC_SHARED = 2'd3
	} outcome_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_RD,
		ST_DOT,
		ST_CHK,
		ST_DIV,
		ST_DECIDE,
		ST_FIN,
		ST_OUT
	} st_t;

	typedef enum logic [1:0] {
		DK_PLANE,
		DK_ALONG,
		DK_ESC
	} dk_t;

	function automatic logic signed [CW-1:0] sat32(input logic signed [XW-1:0] v);
		logic signed [XW-1:0] hi;
		logic signed [XW-1:0] lo;
		hi = XW'(32'sh7fffffff);
		lo = -XW'(33'sh080000000);
		if (v > hi)
			return 32'sh7fffffff;
		else if (v < lo)
			return 32'sh80000000;
		else
			return v[CW-1:0];
	endfunction

endpackage
`default_nettype wire

/* rtl/core/navmesh_face_segment_collide_core.sv */
// Top level: navigation face store and segment collision sequencer.
//
// Channels: input items (kind, a_*, b_*, shared_edge) transfer on in_valid &&
// in_ready; results transfer on out_valid && out_ready. Face normal and vertex
// loads complete in the cycle of their transfer and give no result. A query
// gives exactly one result.
// Sequencing: the block takes one item at a time; in_ready is high only while
// the sequencer is idle. A query runs the plane test, then each loaded edge:
// one RAM read, six products through one shared 33x33 multiplier, a check,
// and when the segment crosses, a bit-serial restoring divide plus a decision
// state; a winning shared edge adds a second divide. Then the lerp/push
// products through the same multiplier and the output state.
// Configuration (cfg_we/cfg_wdata, tolerance) is taken whenever cfg_we is high.
// Reset: tolerance goes to 7, the face normal and vertex count clear; vertex
// RAM contents are not cleared and need no clearing pass.
// Stall: a finished result sits in the output register; the next item is
// accepted meanwhile, and a following query waits at its end for that
// register to drain.
`default_nettype none
module navmesh_face_segment_collide_core #(
	parameter int MAX_VERTICES = nfsc_pkg::NFSC_MAX_VERTICES
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        cfg_we,
	input  wire logic [15:0] cfg_wdata,
	input  wire logic        in_valid,
	output logic             in_ready,
	input  wire logic [1:0]  kind,
	input  wire logic signed [31:0] a_x,
	input  wire logic signed [31:0] a_y,
	input  wire logic signed [31:0] a_z,
	input  wire logic signed [31:0] b_x,
	input  wire logic signed [31:0] b_y,
	input  wire logic signed [31:0] b_z,
	input  wire logic        shared_edge,
	output logic             out_valid,
	input  wire logic        out_ready,
	output logic [1:0]       outcome,
	output logic [3:0]       edge_index,
	output logic signed [31:0] out_from_x,
	output logic signed [31:0] out_from_y,
	output logic signed [31:0] out_from_z,
	output logic signed [31:0] out_to_x,
	output logic signed [31:0] out_to_y,
	output logic signed [31:0] out_to_z
);
	import nfsc_pkg::*;

	localparam int IW   = $clog2(MAX_VERTICES);
	localparam int CNTW = $clog2(MAX_VERTICES + 1);

	st_t state_q, state_d;

	logic [15:0]     tol_q;
	logic [CNTW-1:0] vcount_q;
	logic signed [CW-1:0] fn_q [3];
	logic signed [CW-1:0] a_q  [3];
	logic signed [CW-1:0] b_q  [3];
	logic signed [CW-1:0] bn_q [3];
	logic signed [CW-1:0] rf_q [3];
	logic signed [CW-1:0] rt_q [3];

	logic          is_plane_q;
	logic [IW-1:0] idx_q;
	logic [2:0]    cnt_q;
	logic signed [DW-1:0] td_q, fd_q;
	logic          have_q;
	outcome_t      oc_q;
	logic [3:0]    eidx_q;
	logic signed [48:0]   win_frac_q;
	logic signed [XW-1:0] best_esc_q;

	// divider
	dk_t            dk_q;
	logic [NW-1:0]  den_q;
	logic [NW-1:0]  rem_q;
	logic [DVW-1:0] dvd_q;
	logic [DVW-1:0] quo_q;
	logic           neg_q;
	logic [6:0]     dcnt_q;

	logic signed [65:0] prod_s1;

	// output register
	logic        out_valid_q;
	outcome_t    out_oc_q;
	logic [3:0]  out_eidx_q;
	logic signed [CW-1:0] out_f_q [3];
	logic signed [CW-1:0] out_t_q [3];

	// RAM
	logic           ram_we, ram_re;
	logic [IW-1:0]  ram_waddr, ram_raddr;
	logic [EW-1:0]  ram_wdata, ram_rdata;
	logic signed [CW-1:0] rd_v [3];
	logic signed [CW-1:0] rd_n [3];
	logic           rd_shared;

	logic in_xfer;
	assign in_xfer = in_valid && in_ready;

	assign ram_we    = in_xfer && kind == K_VERT && vcount_q < CNTW'(MAX_VERTICES);
	assign ram_waddr = vcount_q[IW-1:0];
	assign ram_wdata = {shared_edge, b_z, b_y, b_x, a_z, a_y, a_x};
	assign ram_re    = state_q == ST_RD;
	assign ram_raddr = is_plane_q ? '0 : idx_q;

	nfsc_ram #(
		.WIDTH(EW),
		.DEPTH(MAX_VERTICES)
	) u_vram (
		.clk  (clk),
		.we   (ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.re   (ram_re),
		.raddr(ram_raddr),
		.rdata(ram_rdata)
	);

	always_comb begin
		for (int c = 0; c < 3; c++) begin
			rd_v[c] = ram_rdata[CW*c +: CW];
			rd_n[c] = ram_rdata[3*CW + CW*c +: CW];
		end
		rd_shared = ram_rdata[EW-1];
	end

	// term index of the product sitting in prod_s1
	logic [2:0] tj;
	logic [1:0] cc, tc;
	assign tj = cnt_q - 3'd1;
	assign cc = (cnt_q < 3'd3) ? cnt_q[1:0] : 2'(cnt_q - 3'd3);
	assign tc = (tj < 3'd3) ? tj[1:0] : 2'(tj - 3'd3);

	logic signed [XW-1:0] tol52, fd52, td52;
	assign tol52 = XW'({1'b0, tol_q});
	assign fd52  = XW'(fd_q);
	assign td52  = XW'(td_q);

	// clamp of the lerp fraction
	logic signed [XW-1:0] fsrc;
	logic [16:0]          f17;
	logic signed [CW-1:0] esc32;
	always_comb begin
		fsrc = (oc_q == OC_SHARED) ? best_esc_q : XW'(win_frac_q);
		if (fsrc < 0)
			f17 = '0;
		else if (fsrc > XW'(F_ONE))
			f17 = F_ONE;
		else
			f17 = fsrc[16:0];
		esc32 = sat32(best_esc_q);
	end

	// shared multiplier operands
	logic signed [32:0] mul_a, mul_b;
	logic signed [32:0] diff33;
	logic signed [CW-1:0] pt, nrm;
	always_comb begin
		pt     = (cnt_q < 3'd3) ? b_q[cc] : a_q[cc];
		nrm    = is_plane_q ? fn_q[cc] : rd_n[cc];
		diff33 = 33'(pt) - 33'(rd_v[cc]);
		if (state_q == ST_FIN) begin
			if (cnt_q < 3'd3) begin
				mul_a = 33'(b_q[cc]) - 33'(a_q[cc]);
				mul_b = 33'({16'b0, f17});
			end else begin
				mul_a = 33'(bn_q[cc]);
				mul_b = 33'(esc32);
			end
		end else begin
			mul_a = 33'(sat32(XW'(diff33)));
			mul_b = 33'(nrm);
		end
	end

	logic signed [DW-1:0] term;
	assign term = prod_s1[65:16];

	// divider result
	logic [46:0]        qmag;
	logic signed [48:0] div_res;
	assign qmag    = (|quo_q[DVW-1:47]) ? {47{1'b1}} : quo_q[46:0];
	assign div_res = neg_q ? -49'({2'b0, qmag}) : 49'({2'b0, qmag});

	logic [NW:0] rem_sh;
	logic        ge;
	assign rem_sh = {rem_q, dvd_q[DVW-1]};
	assign ge     = rem_sh >= {1'b0, den_q};

	// control decisions
	logic last_test, hit, take, esc_go;
	assign last_test = is_plane_q ? (vcount_q == '0)
	                              : (CNTW'(idx_q) + CNTW'(1) >= vcount_q);
	assign hit  = is_plane_q ? (td_q < 0 && fd_q >= 0) : (td_q > 0 && fd_q <= 0);
	assign take = !have_q || !(div_res > win_frac_q);
	assign esc_go = dk_q == DK_ALONG && take && rd_shared;

	// divider load operands
	logic signed [XW-1:0] dnum, dden;
	always_comb begin
		if (state_q == ST_DECIDE) begin
			dnum = tol52 - fd52;
			dden = td52 - fd52;
		end else if (is_plane_q) begin
			dnum = fd52 - tol52;
			dden = fd52 - td52;
		end else begin
			dnum = -(fd52 + tol52);
			dden = td52 - fd52;
		end
	end
	logic [XW-1:0] dmag;
	assign dmag = dnum[XW-1] ? XW'(-dnum) : XW'(dnum);

	// next state
	always_comb begin
		state_d  = state_q;
		in_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid && kind == K_QUERY)
					state_d = ST_RD;
			end
			ST_RD: state_d = ST_DOT;
			ST_DOT: begin
				if (cnt_q == 3'd6)
					state_d = ST_CHK;
			end
			ST_CHK: begin
				if (hit)
					state_d = ST_DIV;
				else
					state_d = last_test ? ST_FIN : ST_RD;
			end
			ST_DIV: begin
				if (dcnt_q == 7'(DVW - 1))
					state_d = ST_DECIDE;
			end
			ST_DECIDE: begin
				if (esc_go)
					state_d = ST_DIV;
				else
					state_d = last_test ? ST_FIN : ST_RD;
			end
			ST_FIN: begin
				if (cnt_q == 3'd6)
					state_d = ST_OUT;
			end
			ST_OUT: begin
				if (!out_valid_q || out_ready)
					state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n)
			state_q <= ST_IDLE;
		else
			state_q <= state_d;
	end

	logic adv, div_ld;
	assign adv    = state_d == ST_RD && state_q != ST_IDLE;
	assign div_ld = state_d == ST_DIV && state_q != ST_DIV;

	always_ff @(posedge clk) begin
		prod_s1 <= mul_a * mul_b;
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tol_q       <= TOL_RESET;
			vcount_q    <= '0;
			fn_q        <= '{default: '0};
			out_valid_q <= 1'b0;
			is_plane_q  <= 1'b1;
			idx_q       <= '0;
			cnt_q       <= '0;
			dcnt_q      <= '0;
			have_q      <= 1'b0;
			oc_q        <= OC_NONE;
			dk_q        <= DK_PLANE;
		end else begin
			if (cfg_we)
				tol_q <= cfg_wdata;
			if (in_xfer && kind == K_FACE) begin
				fn_q[0]  <= a_x;
				fn_q[1]  <= a_y;
				fn_q[2]  <= a_z;
				vcount_q <= '0;
			end
			if (ram_we)
				vcount_q <= vcount_q + CNTW'(1);
			if (in_xfer && kind == K_QUERY) begin
				is_plane_q <= 1'b1;
				idx_q      <= '0;
				have_q     <= 1'b0;
				oc_q       <= OC_NONE;
			end
			if (adv) begin
				if (is_plane_q) begin
					is_plane_q <= 1'b0;
					idx_q      <= '0;
				end else begin
					idx_q <= idx_q + IW'(1);
				end
			end
			if (state_q == ST_DOT || state_q == ST_FIN)
				cnt_q <= (cnt_q == 3'd6) ? 3'd0 : cnt_q + 3'd1;
			else if (state_d == ST_FIN)
				cnt_q <= '0;
			if (div_ld) begin
				dcnt_q <= '0;
				dk_q   <= (state_q == ST_DECIDE) ? DK_ESC
				        : (is_plane_q ? DK_PLANE : DK_ALONG);
			end else if (state_q == ST_DIV) begin
				dcnt_q <= dcnt_q + 7'd1;
			end
			if (state_q == ST_DECIDE) begin
				case (dk_q)
					DK_PLANE: begin
						have_q <= 1'b1;
						oc_q   <= OC_SURF;
					end
					DK_ALONG: begin
						if (take) begin
							have_q <= 1'b1;
							oc_q   <= rd_shared ? OC_SHARED : OC_WALL;
						end
					end
					default: ;
				endcase
			end
			if (state_q == ST_OUT && state_d == ST_IDLE)
				out_valid_q <= 1'b1;
			else if (out_valid && out_ready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath payload
	always_ff @(posedge clk) begin
		if (in_xfer && kind == K_QUERY) begin
			a_q[0] <= a_x;  a_q[1] <= a_y;  a_q[2] <= a_z;
			b_q[0] <= b_x;  b_q[1] <= b_y;  b_q[2] <= b_z;
			rf_q[0] <= a_x; rf_q[1] <= a_y; rf_q[2] <= a_z;
			rt_q[0] <= b_x; rt_q[1] <= b_y; rt_q[2] <= b_z;
			eidx_q  <= '0;
		end
		if (state_q == ST_DOT && cnt_q != 3'd0) begin
			if (tj < 3'd3)
				td_q <= (tj == 3'd0) ? term : td_q + term;
			else
				fd_q <= (tj == 3'd3) ? term : fd_q + term;
		end
		if (state_q == ST_FIN && cnt_q != 3'd0) begin
			if (tj < 3'd3) begin
				if (oc_q != OC_NONE)
					rf_q[tc] <= sat32(XW'(a_q[tc]) + XW'(term));
			end else begin
				if (oc_q == OC_SURF || oc_q == OC_WALL)
					rt_q[tc] <= sat32(XW'(b_q[tc]) + XW'(term));
			end
		end
		if (div_ld) begin
			neg_q <= dnum[XW-1];
			den_q <= dden[NW-1:0];
			dvd_q <= {dmag[NW-1:0], 16'b0};
			rem_q <= '0;
			quo_q <= '0;
		end else if (state_q == ST_DIV) begin
			rem_q <= ge ? NW'(rem_sh - {1'b0, den_q}) : rem_sh[NW-1:0];
			quo_q <= {quo_q[DVW-2:0], ge};
			dvd_q <= {dvd_q[DVW-2:0], 1'b0};
		end
		if (state_q == ST_DECIDE) begin
			case (dk_q)
				DK_PLANE: begin
					win_frac_q <= div_res;
					best_esc_q <= tol52 - td52;
					bn_q       <= fn_q;
				end
				DK_ALONG: begin
					if (take) begin
						win_frac_q <= div_res;
						if (rd_shared) begin
							eidx_q <= 4'(idx_q);
						end else begin
							best_esc_q <= -(td52 + tol52);
							bn_q       <= rd_n;
						end
					end
				end
				DK_ESC: best_esc_q <= XW'(div_res);
				default: ;
			endcase
		end
		if (state_q == ST_OUT && state_d == ST_IDLE) begin
			out_oc_q   <= oc_q;
			out_eidx_q <= (oc_q == OC_SHARED) ? eidx_q : 4'd0;
			out_f_q    <= rf_q;
			out_t_q    <= rt_q;
		end
	end

	assign out_valid  = out_valid_q;
	assign outcome    = out_oc_q;
	assign edge_index = out_eidx_q;
	assign out_from_x = out_f_q[0];
	assign out_from_y = out_f_q[1];
	assign out_from_z = out_f_q[2];
	assign out_to_x   = out_t_q[0];
	assign out_to_y   = out_t_q[1];
	assign out_to_z   = out_t_q[2];

	a_vcount_bound: assert property (@(posedge clk) disable iff (!arst_n)
		vcount_q <= CNTW'(MAX_VERTICES))
		else $error("vertex count beyond capacity");

	a_eidx_shared: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (outcome == OC_SHARED || edge_index == 4'd0))
		else $error("edge index set without shared crossing");

	a_query_start: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind == K_QUERY) |=> state_q == ST_RD)
		else $error("query transfer did not start a walk");

	a_idle_after_load: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready && kind != K_QUERY) |=> state_q == ST_IDLE)
		else $error("load left the sequencer busy");

endmodule
`default_nettype wire

/* rtl/core/nfsc_ram.sv */
// Generic single-write, single-read RAM with registered read data.
`default_nettype none
module nfsc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic                     re,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we)
			mem[waddr] <= wdata;
		if (re)
			rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* tb/navmesh_face_segment_collide_core_tb.sv */
// Testbench for the navmesh face segment collider: directed and random items, checked by a predictor.
`default_nettype none
module navmesh_face_segment_collide_core_tb;
	import nfsc_pkg::*;

	localparam int NVERT    = 16;
	localparam int WD_LIMIT = 60000; // idle cycles before the run is called hung
	localparam int LONG_HOLD = 3000; // receiver hold-off, in cycles

	typedef struct {
		kind_t kind;
		logic signed [31:0] a [3];
		logic signed [31:0] b [3];
		logic shared;
	} item_t;

	typedef struct {
		outcome_t oc;
		logic [3:0] eidx;
		logic signed [31:0] fr [3];
		logic signed [31:0] to [3];
	} hit_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [15:0] cfg_wdata = '0;
	logic in_valid = 1'b0;
	logic in_ready;
	logic out_valid;
	logic out_ready = 1'b0;
	logic [1:0] outcome;
	logic [3:0] edge_index;
	logic signed [31:0] out_from_x, out_from_y, out_from_z;
	logic signed [31:0] out_to_x, out_to_y, out_to_z;

	// item on the wire; ports follow it, so the payload is stable while valid is high
	item_t cur = '{kind: K_NONE, a: '{0, 0, 0}, b: '{0, 0, 0}, shared: 1'b0};

	navmesh_face_segment_collide_core dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_ready(in_ready),
		.kind(cur.kind),
		.a_x(cur.a[0]), .a_y(cur.a[1]), .a_z(cur.a[2]),
		.b_x(cur.b[0]), .b_y(cur.b[1]), .b_z(cur.b[2]),
		.shared_edge(cur.shared),
		.out_valid(out_valid), .out_ready(out_ready),
		.outcome(outcome), .edge_index(edge_index),
		.out_from_x(out_from_x), .out_from_y(out_from_y), .out_from_z(out_from_z),
		.out_to_x(out_to_x), .out_to_y(out_to_y), .out_to_z(out_to_z)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// ---------------------------------------------------------------
	// Predictor state: face, vertex store, tolerance
	// ---------------------------------------------------------------
	longint face_n [3];
	longint vpos [NVERT][3];
	longint enrm [NVERT][3];
	bit     vshared [NVERT];
	int     vcount;
	longint tol_now = 7;

	item_t pend_q [$];   // items waiting for the driver
	hit_t  hit_q [$];    // predicted results, oldest first
	int    errors = 0;
	int    acc_cnt = 0;
	bit    took = 0;
	bit    sender_hold = 0;
	int    stall_req = 0;

	function automatic longint clip32(longint v);
		if (v > 64'sd2147483647) return 64'sd2147483647;
		if (v < -64'sd2147483648) return -64'sd2147483648;
		return v;
	endfunction

	// floor division by 2^16
	function automatic longint fl16(longint v);
		return v >>> 16;
	endfunction

	function automatic longint plane_dist(longint p [3], longint v [3], longint n [3]);
		longint s;
		s = 0;
		for (int i = 0; i < 3; i++)
			s += fl16(clip32(p[i] - v[i]) * n[i]);
		return s;
	endfunction

	// Q16.16 quotient, truncated toward zero, integer part saturated
	function automatic longint qdiv(longint n, longint d);
		bit neg;
		longint unsigned mag, den, q, r;
		neg = 0;
		if (d < 0) begin
			d = -d;
			n = -n;
		end
		if (n < 0) begin
			neg = 1;
			mag = -n;
		end else begin
			mag = n;
		end
		den = d;
		q = mag / den;
		r = mag % den;
		if (q > 64'h7FFF_FFFF) begin
			q = 64'h7FFF_FFFF_FFFF;
		end else begin
			for (int i = 0; i < 16; i++) begin
				r = r << 1;
				q = q << 1;
				if (r >= den) begin
					r -= den;
					q |= 1;
				end
			end
		end
		return neg ? -longint'(q) : longint'(q);
	endfunction

	function automatic longint unit_clamp(longint f);
		if (f < 0) return 0;
		if (f > 65536) return 65536;
		return f;
	endfunction

	function automatic void slide_from(longint fr [3], longint to [3], longint f,
			output longint res [3]);
		for (int i = 0; i < 3; i++)
			res[i] = clip32(fr[i] + fl16((to[i] - fr[i]) * f));
	endfunction

	// Updates the face store for loads; queues one result for a query.
	task automatic collide_predict(item_t it);
		longint a [3], b [3], rf [3], rt [3], bn [3], v0 [3], vi [3], ni [3];
		longint td, fd, along, win_frac, best_esc, esc;
		bit have;
		outcome_t oc;
		logic [3:0] eidx;
		hit_t h;
		for (int k = 0; k < 3; k++) begin
			a[k] = it.a[k];
			b[k] = it.b[k];
		end
		case (it.kind)
			K_FACE: begin
				face_n = a;
				vcount = 0;
			end
			K_VERT: begin
				if (vcount < NVERT) begin
					vpos[vcount] = a;
					enrm[vcount] = b;
					vshared[vcount] = it.shared;
					vcount++;
				end
			end
			K_QUERY: begin
				have = 0;
				oc = OC_NONE;
				eidx = '0;
				win_frac = 0;
				best_esc = 0;
				bn = face_n;
				v0 = vpos[0];
				td = plane_dist(b, v0, face_n);
				if (td < 0) begin
					fd = plane_dist(a, v0, face_n);
					if (fd >= 0) begin
						win_frac = qdiv(fd - tol_now, fd - td);
						best_esc = tol_now - td;
						oc = OC_SURF;
						have = 1;
					end
				end
				for (int i = 0; i < vcount; i++) begin
					vi = vpos[i];
					ni = enrm[i];
					td = plane_dist(b, vi, ni);
					if (td <= 0) continue;
					fd = plane_dist(a, vi, ni);
					if (fd > 0) continue;
					along = qdiv(fd + tol_now, fd - td);
					// ties go to the later edge
					if (have && along > win_frac) continue;
					have = 1;
					win_frac = along;
					if (!vshared[i]) begin
						oc = OC_WALL;
						bn = ni;
						best_esc = -(td + tol_now);
					end else begin
						oc = OC_SHARED;
						eidx = i[3:0];
						best_esc = qdiv(fd - tol_now, fd - td);
					end
				end
				if (oc == OC_NONE) begin
					rf = a;
					rt = b;
				end else if (oc == OC_SHARED) begin
					slide_from(a, b, unit_clamp(best_esc), rf);
					rt = b;
				end else begin
					esc = clip32(best_esc);
					slide_from(a, b, unit_clamp(win_frac), rf);
					for (int k = 0; k < 3; k++)
						rt[k] = clip32(b[k] + fl16(bn[k] * esc));
				end
				h.oc = oc;
				h.eidx = (oc == OC_SHARED) ? eidx : 4'd0;
				for (int k = 0; k < 3; k++) begin
					h.fr[k] = rf[k][31:0];
					h.to[k] = rt[k][31:0];
				end
				hit_q.push_back(h);
			end
			default: ; // kind three is dropped
		endcase
	endtask

	// ---------------------------------------------------------------
	// Input driver: bursts and gaps, changes at the falling edge
	// ---------------------------------------------------------------
	int burst_left = 8;
	int gap_left = 0;

	always @(negedge clk) begin
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (in_valid && !took) begin
			// hold until the transfer
		end else begin
			took = 0;
			if (gap_left > 0) begin
				gap_left--;
				in_valid <= 1'b0;
			end else if (!sender_hold && pend_q.size() > 0) begin
				cur = pend_q.pop_front();
				in_valid <= 1'b1;
				burst_left--;
				if (burst_left <= 0) begin
					burst_left = $urandom_range(1, 24);
					gap_left = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 12);
				end
			end else begin
				in_valid <= 1'b0;
			end
		end
	end

	// ---------------------------------------------------------------
	// Receiver: ready pattern by mode, plus a long hold-off on request
	// ---------------------------------------------------------------
	int rx_mode = 0;
	int rx_mode_left = 64;
	int rx_hold_left = 0;
	int stall_seen = 0;

	always @(negedge clk) begin
		if (stall_req != stall_seen) begin
			stall_seen = stall_req;
			rx_hold_left = LONG_HOLD;
		end
		if (rx_mode_left == 0) begin
			rx_mode = $urandom_range(0, 2);
			rx_mode_left = $urandom_range(16, 200);
		end else begin
			rx_mode_left--;
		end
		if (!arst_n) begin
			out_ready <= 1'b0;
		end else if (rx_hold_left > 0) begin
			rx_hold_left--;
			out_ready <= 1'b0;
		end else begin
			case (rx_mode)
				0: out_ready <= 1'b1;
				1: out_ready <= $urandom_range(0, 1);
				default: out_ready <= ($urandom_range(0, 3) == 0);
			endcase
		end
	end

	// ---------------------------------------------------------------
	// Monitor and watchdog, sampled at the rising edge
	// ---------------------------------------------------------------
	int idle_cycles = 0;

	always @(posedge clk) begin
		hit_t h;
		logic signed [31:0] got_fr [3], got_to [3];
		if (arst_n) begin
			idle_cycles++;
			if (in_valid && in_ready) begin
				collide_predict(cur);
				took = 1;
				acc_cnt++;
				idle_cycles = 0;
			end
			if (out_valid && out_ready) begin
				idle_cycles = 0;
				got_fr = '{out_from_x, out_from_y, out_from_z};
				got_to = '{out_to_x, out_to_y, out_to_z};
				if (hit_q.size() == 0) begin
					errors++;
					$display("%0t: result with nothing predicted: outcome %0d", $time, outcome);
				end else begin
					h = hit_q.pop_front();
					if (outcome !== h.oc) begin
						errors++;
						$display("%0t: outcome exp %0d got %0d", $time, h.oc, outcome);
					end
					if (edge_index !== h.eidx) begin
						errors++;
						$display("%0t: edge_index exp %0d got %0d", $time, h.eidx, edge_index);
					end
					for (int k = 0; k < 3; k++) begin
						if (got_fr[k] !== h.fr[k]) begin
							errors++;
							$display("%0t: out_from[%0d] exp %h got %h", $time, k,
								h.fr[k], got_fr[k]);
						end
						if (got_to[k] !== h.to[k]) begin
							errors++;
							$display("%0t: out_to[%0d] exp %h got %h", $time, k,
								h.to[k], got_to[k]);
						end
					end
				end
			end
			if (idle_cycles >= WD_LIMIT) begin
				$display("Verification failed");
				$finish;
			end
		end
	end

	// ---------------------------------------------------------------
	// Stimulus
	// ---------------------------------------------------------------
	int gen_count = 0;  // vertices in the face being built
	bit gen_v0 = 0;     // vertex 0 has been written at least once
	int gen_items = 0;

	task automatic push(kind_t k, longint ax, longint ay, longint az,
			longint bx, longint by, longint bz, bit sh);
		item_t it;
		it.kind = k;
		it.a = '{ax[31:0], ay[31:0], az[31:0]};
		it.b = '{bx[31:0], by[31:0], bz[31:0]};
		it.shared = sh;
		pend_q.push_back(it);
		gen_items++;
		if (k == K_FACE) gen_count = 0;
		if (k == K_VERT && gen_count < NVERT) begin
			if (gen_count == 0) gen_v0 = 1;
			gen_count++;
		end
	endtask

	// coordinate at a random scale; now and then the full 32-bit range
	function automatic longint rcoord();
		int sh;
		if ($urandom_range(0, 15) == 0)
			return longint'(int'($urandom));
		sh = $urandom_range(8, 13);
		return longint'(int'($urandom) >>> sh);
	endfunction

	function automatic longint rnorm();
		case ($urandom_range(0, 5))
			0: return 0;
			1: return 65536;
			2: return -65536;
			3: return longint'(int'($urandom));
			default: return longint'(int'($urandom) >>> 14);
		endcase
	endfunction

	task automatic rand_face();
		int nv;
		nv = ($urandom_range(0, 15) == 0) ? $urandom_range(14, 18) : $urandom_range(1, 6);
		push(K_FACE, rnorm(), rnorm(), rnorm(), rcoord(), rcoord(), rcoord(), $urandom_range(0, 1));
		for (int i = 0; i < nv; i++)
			push(K_VERT, rcoord(), rcoord(), rcoord(), rnorm(), rnorm(), rnorm(),
				$urandom_range(0, 1));
	endtask

	task automatic rand_phase(int n);
		int stop;
		stop = gen_items + n;
		while (gen_items < stop) begin
			case ($urandom_range(0, 19))
				0: push(K_NONE, rcoord(), rcoord(), rcoord(), rcoord(), rcoord(), rcoord(),
					$urandom_range(0, 1));
				1: push(K_FACE, rnorm(), rnorm(), rnorm(), 0, 0, 0, 0); // bare face reload
				2, 3, 4: rand_face();
				default: begin
					if (gen_v0)
						push(K_QUERY, rcoord(), rcoord(), rcoord(), rcoord(), rcoord(), rcoord(),
							$urandom_range(0, 1));
					else
						rand_face();
				end
			endcase
		end
	endtask

	task automatic drain();
		wait (pend_q.size() == 0 && !in_valid && hit_q.size() == 0);
		// loads give no result; let the last one settle before touching config
		repeat (20) @(posedge clk);
	endtask

	task automatic set_tol(logic [15:0] v);
		@(negedge clk);
		cfg_we = 1'b1;
		cfg_wdata = v;
		@(negedge clk);
		cfg_we = 1'b0;
		tol_now = v;
	endtask

	localparam longint U = 65536;

	initial begin
		int base;
		repeat (6) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// directed: square face in z = 0, edge 1 shared, reset tolerance
		push(K_FACE, 0, 0, U, 0, 0, 0, 0);
		push(K_VERT, 0, 0, 0, 0, -U, 0, 0);
		push(K_VERT, 10 * U, 0, 0, U, 0, 0, 1);
		push(K_VERT, 10 * U, 10 * U, 0, 0, U, 0, 0);
		push(K_VERT, 0, 10 * U, 0, -U, 0, 0, 0);
		push(K_QUERY, 5 * U, 5 * U, U, 5 * U, 5 * U, -U, 0);   // surface crossing
		push(K_QUERY, 5 * U, 5 * U, 0, 15 * U, 5 * U, 0, 0);   // shared edge
		push(K_QUERY, 5 * U, 5 * U, 0, 5 * U, -5 * U, 0, 0);   // wall edge
		push(K_QUERY, 2 * U, 2 * U, 0, 3 * U, 3 * U, 0, 0);    // no crossing
		push(K_QUERY, 5 * U, 5 * U, 0, 15 * U, 15 * U, 0, 0);  // tie on a corner
		push(K_QUERY, 5 * U, 5 * U, U, 15 * U, 5 * U, -U, 1);  // surface against edge
		push(K_QUERY, 32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff,
			-32'sh80000000, -32'sh80000000, -32'sh80000000, 1);
		push(K_QUERY, -32'sh80000000, 32'sh7fffffff, -32'sh80000000,
			32'sh7fffffff, -32'sh80000000, 32'sh7fffffff, 0);
		push(K_NONE, -1, -1, -1, -1, -1, -1, 1);
		push(K_FACE, 32'sh7fffffff, -32'sh80000000, -1, -1, -1, -1, 1);
		for (int i = 0; i < 17; i++) // the last load finds the store full
			push(K_VERT, i * U, -i * U, (i & 1) ? -1 : 0, -U, U, (i & 2) ? U : -U, i & 1);
		push(K_QUERY, 32'sh7fffffff, 0, -32'sh80000000, -32'sh80000000, 0, 32'sh7fffffff, 0);
		push(K_QUERY, 3 * U, -3 * U, U, -20 * U, 20 * U, -U, 0);
		drain();

		set_tol(16'd0);
		rand_phase(350);
		drain();

		// receiver holds off while the sender keeps offering
		set_tol(16'hFFFF);
		base = acc_cnt;
		rand_phase(350);
		wait (acc_cnt >= base + 40 || pend_q.size() == 0);
		stall_req++;
		drain();

		// sender pauses until every result is back
		set_tol($urandom_range(1, 16'hFFFE));
		base = acc_cnt;
		rand_phase(350);
		wait (acc_cnt >= base + 100 || pend_q.size() == 0);
		sender_hold = 1;
		wait (hit_q.size() == 0);
		repeat (10) @(posedge clk);
		sender_hold = 0;
		drain();

		set_tol(16'd7);
		rand_phase(350);
		drain();

		repeat (200) @(posedge clk);
		if (errors == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end

endmodule
`default_nettype wire
